// ===== sv/drs_pkg.sv =====
// Shared types, constants and codes for the directory record search block.
// Depends on nothing; every other file refers to it by scoped names.
package drs_pkg;

  // Sector and search-name geometry.
  localparam int SECTOR_BYTES = 2048;
  localparam int NAME_BYTES   = 128;
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int SECT_W       = SECTOR_SHIFT;
  localparam int CNT_W        = 32 - SECTOR_SHIFT;
  localparam int NAME_AW      = $clog2(NAME_BYTES);
  localparam int NLEN_W       = $clog2(NAME_BYTES + 1);

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Byte offsets inside a directory record.
  localparam logic [7:0] OFF_EXTENT_LO = 8'd2;
  localparam logic [7:0] OFF_EXTENT_HI = 8'd5;
  localparam logic [7:0] OFF_SIZE_LO   = 8'd10;
  localparam logic [7:0] OFF_SIZE_HI   = 8'd13;
  localparam logic [7:0] OFF_FLAGS     = 8'd25;
  localparam logic [7:0] OFF_NAME_LEN  = 8'd32;
  localparam logic [7:0] OFF_NAME      = 8'd33;
  localparam int         FLAG_DIR_BIT  = 1;

  // Input operation codes.
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_BYTE   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_REQUEST   = 2'd0;
  localparam logic [1:0] KIND_FOUND     = 2'd1;
  localparam logic [1:0] KIND_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic [31:0] dir_lba;
    logic [31:0] dir_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] lba;
    logic [31:0] size;
  } out_item_t;

  // Classified command as it travels through the queue.
  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_START,
    CMD_BYTE,
    CMD_NOP
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [7:0]       data_byte;
    logic [31:0]      lba;
    logic [CNT_W-1:0] last_sector;
    logic             dir_empty;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== sv/directory_record_search.sv =====
// Top level of the directory record search block: front end, command queue
// and back end. Depends on drs_pkg, drs_front, drs_queue and drs_back.
//
//   Channel   Direction  Payload              Handshake
//   in_       input      drs_pkg::in_item_t   in_valid / in_ready
//   out_      output     drs_pkg::out_item_t  out_valid / out_ready
//
// The front end decodes each input transfer combinationally into the queue;
// the back end's per-byte record parser, with one search-name read registered
// ahead, takes one item per cycle while the result register is not stalled.
// A four-entry queue sits between front and back, and the result register
// lets new items be processed in the cycle its result is taken.
// Reset is synchronous and active low; the search-name store is not reset and
// needs no clearing pass, since only entries below the name length are used.
// A stall on out_ready holds the back end, and the queue then fills before
// in_ready drops.
module directory_record_search (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  drs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output drs_pkg::out_item_t out_data
);

  drs_pkg::q_status_t q_stat;
  drs_pkg::q_item_t   push_item;
  drs_pkg::q_item_t   head;
  logic               push;
  logic               pop;

  // Decodes each input transfer and pushes it into the queue.
  drs_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // Decouples the front end from result-side stalls.
  drs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Runs the search and owns the result register.
  drs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sv/drs_front.sv =====
// Front end: takes input transfers, decodes the operation and works out the
// last sector index of a start. Depends on drs_pkg.
module drs_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  drs_pkg::in_item_t  in_data,
  input  drs_pkg::q_status_t q_stat,
  output logic               push,
  output drs_pkg::q_item_t   push_item
);

  logic [drs_pkg::CNT_W-1:0] whole_sectors;
  logic                      partial;

  assign in_ready      = !q_stat.full;
  assign push          = in_valid && !q_stat.full;
  assign whole_sectors = in_data.dir_length[31:drs_pkg::SECTOR_SHIFT];
  assign partial       = |in_data.dir_length[drs_pkg::SECTOR_SHIFT-1:0];

  always_comb begin
    push_item.data_byte   = in_data.data_byte;
    push_item.lba         = in_data.dir_lba;
    push_item.dir_empty   = (in_data.dir_length == 32'd0);
    // Index of the last sector: ceil(size / sector) - 1.
    push_item.last_sector = partial ? whole_sectors
                                    : whole_sectors - drs_pkg::CNT_W'(1);
    unique case (in_data.operation)
      drs_pkg::OP_APPEND: push_item.cmd = drs_pkg::CMD_APPEND;
      drs_pkg::OP_START:  push_item.cmd = drs_pkg::CMD_START;
      drs_pkg::OP_BYTE:   push_item.cmd = drs_pkg::CMD_BYTE;
      default:            push_item.cmd = drs_pkg::CMD_NOP;
    endcase
  end

endmodule

// ===== sv/drs_queue.sv =====
// Short queue of classified commands between the front and the back.
// Depends on drs_pkg.
module drs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  drs_pkg::q_item_t   push_item,
  input  logic               pop,
  output drs_pkg::q_item_t   head,
  output drs_pkg::q_status_t q_stat
);

  drs_pkg::q_item_t                slot_r [drs_pkg::QUEUE_DEPTH];
  logic [drs_pkg::QUEUE_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [drs_pkg::QUEUE_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [drs_pkg::QUEUE_AW:0]      count_r, count_nxt;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = (count_r == (drs_pkg::QUEUE_AW+1)'(drs_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == drs_pkg::QUEUE_AW'(drs_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_r + drs_pkg::QUEUE_AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == drs_pkg::QUEUE_AW'(drs_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_r + drs_pkg::QUEUE_AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (drs_pkg::QUEUE_AW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (drs_pkg::QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/drs_back.sv =====
// Back end: holds the search name and the search state, parses directory
// records one byte per cycle while the result register is not stalled, and
// drives the result register. Depends on drs_pkg.
module drs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  drs_pkg::q_item_t   head,
  input  drs_pkg::q_status_t q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output drs_pkg::out_item_t out_data
);

  // Search name store, no reset.
  logic [7:0] name_mem [drs_pkg::NAME_BYTES];
  logic [7:0] name_rd_r;
  logic       name_wr;
  logic [drs_pkg::NAME_AW-1:0] name_rd_addr;

  logic                        searching_r, searching_nxt;
  logic [drs_pkg::NLEN_W-1:0]  srch_len_r, srch_len_nxt;
  logic [31:0]                 next_sector_r, next_sector_nxt;
  logic [drs_pkg::CNT_W-1:0]   sectors_left_r, sectors_left_nxt;
  logic [drs_pkg::SECT_W-1:0]  byte_pos_r, byte_pos_nxt;
  logic [7:0]                  rec_len_r, rec_len_nxt;
  logic [7:0]                  rec_off_r, rec_off_nxt;
  logic [31:0]                 ext_loc_r, ext_loc_nxt;
  logic [31:0]                 ext_size_r, ext_size_nxt;
  logic [7:0]                  flags_r, flags_nxt;
  logic [7:0]                  rec_nlen_r, rec_nlen_nxt;
  logic                        match_r, match_nxt;
  logic [7:0]                  first_r, first_nxt;
  logic                        skip_r, skip_nxt;
  logic                        out_valid_r, out_valid_nxt;
  drs_pkg::out_item_t          out_r, out_nxt;

  logic       go;
  logic       hit;
  logic       emit;
  logic [7:0] b;
  logic [7:0] idx;
  logic [7:0] first_v;
  logic       match_v;
  logic [1:0] lane;

  // A record named "\0" or "\1" of length one is the dot or dot-dot entry.
  function automatic logic decide(input logic [7:0] rlen, input logic [7:0] first,
                                  input logic [7:0] flags, input logic name_eq);
    logic dot;
    dot = (rlen == 8'd1) && (first <= 8'd1);
    return !dot && flags[drs_pkg::FLAG_DIR_BIT] && name_eq;
  endfunction

  assign go        = !q_stat.empty && (!out_valid_r || out_ready);
  assign pop       = go;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign b         = head.data_byte;
  assign name_rd_addr = drs_pkg::NAME_AW'(rec_off_nxt - drs_pkg::OFF_NAME);

  always_comb begin
    searching_nxt    = searching_r;
    srch_len_nxt     = srch_len_r;
    next_sector_nxt  = next_sector_r;
    sectors_left_nxt = sectors_left_r;
    byte_pos_nxt     = byte_pos_r;
    rec_len_nxt      = rec_len_r;
    rec_off_nxt      = rec_off_r;
    ext_loc_nxt      = ext_loc_r;
    ext_size_nxt     = ext_size_r;
    flags_nxt        = flags_r;
    rec_nlen_nxt     = rec_nlen_r;
    match_nxt        = match_r;
    first_nxt        = first_r;
    skip_nxt         = skip_r;
    name_wr          = 1'b0;
    hit              = 1'b0;
    emit             = 1'b0;
    out_nxt          = out_r;
    idx              = rec_off_r - drs_pkg::OFF_NAME;
    first_v          = first_r;
    match_v          = match_r;
    lane             = 2'd0;

    if (go) begin
      case (head.cmd)
        drs_pkg::CMD_APPEND: begin
          if (!searching_r && (b != 8'd0) &&
              (srch_len_r < drs_pkg::NLEN_W'(drs_pkg::NAME_BYTES))) begin
            name_wr      = 1'b1;
            srch_len_nxt = srch_len_r + drs_pkg::NLEN_W'(1);
          end
        end
        drs_pkg::CMD_START: begin
          emit = 1'b1;
          if (head.dir_empty) begin
            searching_nxt = 1'b0;
            srch_len_nxt  = '0;
            out_nxt       = '{kind: drs_pkg::KIND_NOT_FOUND, lba: 32'd0, size: 32'd0};
          end else begin
            searching_nxt    = 1'b1;
            sectors_left_nxt = head.last_sector;
            next_sector_nxt  = head.lba + 32'd1;
            byte_pos_nxt     = '0;
            rec_len_nxt      = 8'd0;
            rec_off_nxt      = 8'd0;
            skip_nxt         = 1'b0;
            out_nxt          = '{kind: drs_pkg::KIND_REQUEST, lba: head.lba, size: 32'd0};
          end
        end
        drs_pkg::CMD_BYTE: begin
          if (searching_r) begin
            if (!skip_r) begin
              if (rec_len_r == 8'd0) begin
                // Length byte: zero skips the rest of the sector.
                if (b == 8'd0) begin
                  skip_nxt = 1'b1;
                end else begin
                  rec_len_nxt   = (b == 8'd1) ? 8'd0 : b;
                  rec_off_nxt   = 8'd1;
                  ext_loc_nxt   = 32'd0;
                  ext_size_nxt  = 32'd0;
                  flags_nxt     = 8'd0;
                  rec_nlen_nxt  = 8'd0;
                  match_nxt     = 1'b1;
                  first_nxt     = 8'd0;
                end
              end else begin
                if (rec_off_r >= drs_pkg::OFF_EXTENT_LO &&
                    rec_off_r <= drs_pkg::OFF_EXTENT_HI) begin
                  lane = 2'(rec_off_r - drs_pkg::OFF_EXTENT_LO);
                  ext_loc_nxt[lane*8 +: 8] = b;
                end else if (rec_off_r >= drs_pkg::OFF_SIZE_LO &&
                             rec_off_r <= drs_pkg::OFF_SIZE_HI) begin
                  lane = 2'(rec_off_r - drs_pkg::OFF_SIZE_LO);
                  ext_size_nxt[lane*8 +: 8] = b;
                end else if (rec_off_r == drs_pkg::OFF_FLAGS) begin
                  flags_nxt = b;
                end else if (rec_off_r == drs_pkg::OFF_NAME_LEN) begin
                  rec_nlen_nxt = b;
                  match_nxt    = (9'(b) == 9'(srch_len_r));
                  // An empty record name is decided right here.
                  if (b == 8'd0) begin
                    hit = flags_r[drs_pkg::FLAG_DIR_BIT] && (srch_len_r == '0);
                  end
                end else if (rec_off_r >= drs_pkg::OFF_NAME &&
                             9'(rec_off_r) < 9'(drs_pkg::OFF_NAME) + 9'(rec_nlen_r)) begin
                  first_v   = (idx == 8'd0) ? b : first_r;
                  match_v   = match_r && (9'(idx) < 9'(srch_len_r)) && (name_rd_r == b);
                  first_nxt = first_v;
                  match_nxt = match_v;
                  if (9'(idx) + 9'd1 == 9'(rec_nlen_r)) begin
                    hit = decide(rec_nlen_r, first_v, flags_r, match_v);
                  end
                end
                rec_off_nxt = rec_off_r + 8'd1;
                if (9'(rec_off_r) + 9'd1 >= 9'(rec_len_r)) begin
                  rec_len_nxt = 8'd0;
                end
              end
            end

            if (hit) begin
              emit          = 1'b1;
              searching_nxt = 1'b0;
              srch_len_nxt  = '0;
              out_nxt       = '{kind: drs_pkg::KIND_FOUND, lba: ext_loc_r, size: ext_size_r};
            end else begin
              byte_pos_nxt = byte_pos_r + drs_pkg::SECT_W'(1);
              if (byte_pos_r == drs_pkg::SECT_W'(drs_pkg::SECTOR_BYTES - 1)) begin
                emit = 1'b1;
                if (sectors_left_r == '0) begin
                  searching_nxt = 1'b0;
                  srch_len_nxt  = '0;
                  out_nxt = '{kind: drs_pkg::KIND_NOT_FOUND, lba: 32'd0, size: 32'd0};
                end else begin
                  sectors_left_nxt = sectors_left_r - drs_pkg::CNT_W'(1);
                  next_sector_nxt  = next_sector_r + 32'd1;
                  byte_pos_nxt     = '0;
                  rec_len_nxt      = 8'd0;
                  rec_off_nxt      = 8'd0;
                  skip_nxt         = 1'b0;
                  out_nxt = '{kind: drs_pkg::KIND_REQUEST, lba: next_sector_r, size: 32'd0};
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      searching_r    <= 1'b0;
      srch_len_r     <= '0;
      next_sector_r  <= 32'd0;
      sectors_left_r <= '0;
      byte_pos_r     <= '0;
      rec_len_r      <= 8'd0;
      rec_off_r      <= 8'd0;
      ext_loc_r      <= 32'd0;
      ext_size_r     <= 32'd0;
      flags_r        <= 8'd0;
      rec_nlen_r     <= 8'd0;
      match_r        <= 1'b1;
      first_r        <= 8'd0;
      skip_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      searching_r    <= searching_nxt;
      srch_len_r     <= srch_len_nxt;
      next_sector_r  <= next_sector_nxt;
      sectors_left_r <= sectors_left_nxt;
      byte_pos_r     <= byte_pos_nxt;
      rec_len_r      <= rec_len_nxt;
      rec_off_r      <= rec_off_nxt;
      ext_loc_r      <= ext_loc_nxt;
      ext_size_r     <= ext_size_nxt;
      flags_r        <= flags_nxt;
      rec_nlen_r     <= rec_nlen_nxt;
      match_r        <= match_nxt;
      first_r        <= first_nxt;
      skip_r         <= skip_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // The read port follows the next record offset, so the name byte for the
  // following sector byte is already registered when that byte arrives.
  always_ff @(posedge clk) begin
    if (name_wr) begin
      name_mem[srch_len_r[drs_pkg::NAME_AW-1:0]] <= b;
    end
    name_rd_r <= name_mem[name_rd_addr];
  end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for directory_record_search: it loads names, starts
// searches and streams directory records, then checks every result transfer.
// Depends on drs_pkg for the payload structs, the codes and the record offsets.
module tb_top;

  // The fourth operation code has no meaning; the block must drop it.
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [7:0] DIR_FLAG     = 8'h02;
  localparam int         RANDOM_ITEMS = 1900;
  localparam int         SETTLE_CYCLES = 20;

  typedef logic [7:0] octets_t[$];

  // Scoreboard: a cycle-free copy of the search state that works out the
  // result of every accepted input transfer, plus the queue of results still
  // owed by the block.
  class search_scoreboard;
    logic [7:0]  name_mem [drs_pkg::NAME_BYTES];
    int unsigned srch_len;
    logic [31:0] next_lba;
    int unsigned sectors_left;
    int unsigned byte_pos;
    int unsigned rec_len;
    int unsigned rec_off;
    int unsigned rec_nlen;
    logic [31:0] ext_loc;
    logic [31:0] ext_size;
    logic [7:0]  rec_flags;
    logic [7:0]  first_byte;
    bit          name_ok;
    bit          skip_rest;
    bit          searching;
    drs_pkg::out_item_t owed_q[$];
    int          errors;

    function new();
      srch_len = 0;
      next_lba = '0;
      sectors_left = 0;
      byte_pos = 0;
      rec_len = 0;
      rec_off = 0;
      rec_nlen = 0;
      ext_loc = '0;
      ext_size = '0;
      rec_flags = '0;
      first_byte = '0;
      name_ok = 1;
      skip_rest = 0;
      searching = 0;
      errors = 0;
    endfunction

    // A search ends on found or not found, and the name goes with it.
    function void owe(logic [1:0] k, logic [31:0] lba, logic [31:0] sz, bit ends);
      drs_pkg::out_item_t r;
      r.kind = k;
      r.lba  = lba;
      r.size = sz;
      if (ends) begin
        searching = 0;
        srch_len = 0;
      end
      owed_q.push_back(r);
    endfunction

    // The dot and dot-dot entries never count as a hit.
    function bit dir_hit();
      if (rec_nlen == 1 && first_byte <= 8'd1) return 0;
      return rec_flags[drs_pkg::FLAG_DIR_BIT] && name_ok;
    endfunction

    function void note_input(drs_pkg::in_item_t it);
      logic [7:0]        b;
      logic [31:0]       lba;
      int unsigned       o;
      int unsigned       i;
      longint unsigned   count;
      bit                hit;
      b = it.data_byte;
      hit = 0;
      case (it.operation)
        drs_pkg::OP_APPEND: begin
          if (!searching && b != 8'd0 && srch_len < drs_pkg::NAME_BYTES) begin
            name_mem[srch_len] = b;
            srch_len++;
          end
        end
        drs_pkg::OP_START: begin
          count = ({32'd0, it.dir_length} + drs_pkg::SECTOR_BYTES - 1)
                  / drs_pkg::SECTOR_BYTES;
          if (count == 0) begin
            owe(drs_pkg::KIND_NOT_FOUND, '0, '0, 1);
          end else begin
            searching = 1;
            sectors_left = count - 1;
            next_lba = it.dir_lba + 32'd1;
            byte_pos = 0;
            rec_len = 0;
            rec_off = 0;
            skip_rest = 0;
            owe(drs_pkg::KIND_REQUEST, it.dir_lba, '0, 0);
          end
        end
        drs_pkg::OP_BYTE: begin
          if (searching) begin
            if (!skip_rest) begin
              if (rec_len == 0) begin
                // A length byte opens a record; zero skips the sector's rest.
                if (b == 8'd0) begin
                  skip_rest = 1;
                end else begin
                  rec_len = b;
                  rec_off = 1;
                  ext_loc = '0;
                  ext_size = '0;
                  rec_flags = '0;
                  rec_nlen = 0;
                  name_ok = 1;
                  first_byte = '0;
                  if (rec_len == 1) rec_len = 0;
                end
              end else begin
                o = rec_off;
                if (o >= drs_pkg::OFF_EXTENT_LO && o <= drs_pkg::OFF_EXTENT_HI) begin
                  ext_loc[8*(o-drs_pkg::OFF_EXTENT_LO) +: 8] = b;
                end else if (o >= drs_pkg::OFF_SIZE_LO && o <= drs_pkg::OFF_SIZE_HI) begin
                  ext_size[8*(o-drs_pkg::OFF_SIZE_LO) +: 8] = b;
                end else if (o == drs_pkg::OFF_FLAGS) begin
                  rec_flags = b;
                end else if (o == drs_pkg::OFF_NAME_LEN) begin
                  rec_nlen = b;
                  name_ok = (b == srch_len);
                  if (b == 8'd0) hit = dir_hit();
                end else if (o >= drs_pkg::OFF_NAME && o < drs_pkg::OFF_NAME + rec_nlen) begin
                  i = o - drs_pkg::OFF_NAME;
                  if (i == 0) first_byte = b;
                  if (i >= srch_len || i >= drs_pkg::NAME_BYTES || name_mem[i] != b)
                    name_ok = 0;
                  if (i + 1 == rec_nlen) hit = dir_hit();
                end
                rec_off = o + 1;
                if (rec_off >= rec_len) rec_len = 0;
              end
            end
            if (hit) begin
              owe(drs_pkg::KIND_FOUND, ext_loc, ext_size, 1);
            end else begin
              byte_pos++;
              if (byte_pos >= drs_pkg::SECTOR_BYTES) begin
                if (sectors_left == 0) begin
                  owe(drs_pkg::KIND_NOT_FOUND, '0, '0, 1);
                end else begin
                  lba = next_lba;
                  sectors_left--;
                  next_lba = lba + 32'd1;
                  byte_pos = 0;
                  rec_len = 0;
                  rec_off = 0;
                  skip_rest = 0;
                  owe(drs_pkg::KIND_REQUEST, lba, '0, 0);
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 200) $display("tb_top: mismatch: %s", msg);
    endtask

    task check_result(drs_pkg::out_item_t got);
      drs_pkg::out_item_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result with none owed: kind %0d lba %h size %h",
                         got.kind, got.lba, got.size));
        return;
      end
      want = owed_q.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
      if (got.lba !== want.lba)
        report($sformatf("lba %h, wanted %h (kind %0d)", got.lba, want.lba, want.kind));
      if (got.size !== want.size)
        report($sformatf("size %h, wanted %h (kind %0d)", got.size, want.size, want.kind));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  drs_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  drs_pkg::out_item_t out_data;

  int sender_idle_pct;
  int receiver_stall_pct;
  int sent_count;
  logic [7:0] dir_bytes[$];
  search_scoreboard sb;

  directory_record_search DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The run is cut off well beyond the slowest legal run.
  initial begin
    #4000000;
    $display("tb_top: FAIL");
    $finish;
  end

  // The receiver decides at each falling edge whether it stalls the next
  // cycle; a result transfer is taken at the rising edge where both are high.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // One input transfer. The task starts and ends at a falling edge, so a
  // back-to-back item keeps in_valid high without lowering it in between.
  task automatic send(logic [1:0] op, logic [7:0] b, logic [31:0] lba, logic [31:0] sz);
    drs_pkg::in_item_t it;
    it.operation  = op;
    it.data_byte  = b;
    it.dir_lba    = lba;
    it.dir_length = sz;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    if (op != OP_UNUSED) sent_count++;
    @(negedge clk);
  endtask

  // Fields that the operation does not use still carry random values.
  task automatic send_byte(logic [1:0] op, logic [7:0] b);
    send(op, b, $urandom, $urandom);
  endtask

  // The sender holds off until every owed result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.owed_q.size() != 0) @(negedge clk);
  endtask

  // Appends name characters; now and then a zero byte, which must be dropped.
  task automatic load_name(int n);
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(9) == 0) send_byte(drs_pkg::OP_APPEND, 8'd0);
      send_byte(drs_pkg::OP_APPEND, 8'($urandom_range(1, 255)));
    end
  endtask

  // Builds one directory record into dir_bytes. A negative length gives the
  // full record, padded to an even size; a shorter one cuts the record off.
  task automatic add_record(int len, logic [31:0] ext, logic [31:0] sz,
                            logic [7:0] flags, octets_t nm);
    logic [7:0] rec [256];
    for (int j = 0; j < 256; j++) rec[j] = 8'($urandom_range(255));
    if (len < 0) begin
      len = int'(drs_pkg::OFF_NAME) + nm.size();
      if (len % 2 != 0 && len < 255) len++;
    end
    rec[0] = 8'(len);
    for (int j = 0; j < 4; j++) begin
      rec[int'(drs_pkg::OFF_EXTENT_LO) + j] = ext[8*j +: 8];
      rec[int'(drs_pkg::OFF_SIZE_LO) + j]   = sz[8*j +: 8];
    end
    rec[drs_pkg::OFF_FLAGS]    = flags;
    rec[drs_pkg::OFF_NAME_LEN] = 8'(nm.size());
    for (int j = 0; j < nm.size(); j++) rec[int'(drs_pkg::OFF_NAME) + j] = nm[j];
    for (int j = 0; j < len; j++) dir_bytes.push_back(rec[j]);
  endtask

  // One search: optional dot entries, records that come close to the name without
  // matching or are random, an optional real match, then the start and the streamed
  // bytes. Streaming stops once the search has ended; a search still running is
  // left to be abandoned by the next start.
  task automatic directory_search(int fill, bit with_match, logic [31:0] lba,
                                  logic [31:0] sz, int tail);
    octets_t nm;
    octets_t other;
    int      k;
    int      j;
    dir_bytes.delete();
    for (j = 0; j < sb.srch_len; j++) nm.push_back(sb.name_mem[j]);
    if ($urandom_range(1) == 1) begin
      add_record(-1, $urandom, $urandom, DIR_FLAG, '{8'h00});
      add_record(-1, $urandom, $urandom, DIR_FLAG, '{8'h01});
    end
    while (dir_bytes.size() < fill) begin
      other = nm;
      case ($urandom_range(9))
        0: add_record(-1, $urandom, $urandom, 8'($urandom) & ~DIR_FLAG, nm);
        1: begin
          if (other.size() > 0) begin
            j = $urandom_range(other.size() - 1);
            other[j] = other[j] ^ 8'($urandom_range(1, 255));
          end else begin
            other.push_back(8'($urandom_range(1, 255)));
          end
          add_record(-1, $urandom, $urandom, DIR_FLAG, other);
        end
        2: begin
          other.push_back(8'($urandom_range(255)));
          add_record(-1, $urandom, $urandom, DIR_FLAG, other);
        end
        3: begin
          if (other.size() > 0) void'(other.pop_back());
          add_record(-1, $urandom, $urandom, DIR_FLAG, other);
        end
        4: add_record($urandom_range(1, int'(drs_pkg::OFF_NAME) + nm.size() - 1),
                      $urandom, $urandom, 8'($urandom) | DIR_FLAG, nm);
        5: begin
          if ($urandom_range(3) == 0) dir_bytes.push_back(8'd0);
        end
        default: begin
          other.delete();
          for (j = $urandom_range(1, 12); j > 0; j--) other.push_back(8'($urandom));
          add_record(-1, $urandom, $urandom, 8'($urandom), other);
        end
      endcase
    end
    if (with_match) add_record(-1, $urandom, $urandom, 8'($urandom) | DIR_FLAG, nm);

    send(drs_pkg::OP_START, 8'($urandom), lba, sz);
    k = 0;
    while (k < dir_bytes.size() && sb.searching) begin
      // Appends and unused codes mid-stream must leave the search alone.
      if ($urandom_range(49) == 0)
        send_byte(($urandom_range(1) == 1) ? drs_pkg::OP_APPEND : OP_UNUSED,
                  8'($urandom));
      send_byte(drs_pkg::OP_BYTE, dir_bytes[k]);
      k++;
    end
    k = 0;
    while (k < tail && sb.searching) begin
      send_byte(drs_pkg::OP_BYTE, 8'($urandom));
      k++;
    end
    // Bytes after the search has ended are dropped by the block.
    if (!sb.searching && $urandom_range(3) == 0) send_byte(drs_pkg::OP_BYTE, 8'($urandom));
  endtask

  task automatic random_search();
    logic [31:0] lba;
    logic [31:0] sz;
    int          pick;
    pick = $urandom_range(19);
    if (pick == 1) begin
      // A name of one 0x01 character looks like the dot-dot entry.
      send_byte(drs_pkg::OP_APPEND, 8'h01);
    end else if (pick == 2) begin
      load_name(drs_pkg::NAME_BYTES + $urandom_range(0, 6));
    end else if (pick != 0) begin
      load_name($urandom_range(1, 12));
    end
    case ($urandom_range(9))
      0:       sz = '0;
      1:       sz = $urandom;
      2:       sz = $urandom_range(drs_pkg::SECTOR_BYTES + 1, 4 * drs_pkg::SECTOR_BYTES);
      default: sz = $urandom_range(1, drs_pkg::SECTOR_BYTES);
    endcase
    case ($urandom_range(9))
      0:       lba = 32'hFFFF_FFFF;
      1:       lba = '0;
      default: lba = $urandom;
    endcase
    directory_search($urandom_range(0, 300), $urandom_range(3) != 0, lba, sz,
                     $urandom_range(0, 40));
  endtask

  initial begin
    int idle_by_phase  [4];
    int stall_by_phase [4];
    int target;
    idle_by_phase  = '{0, 45, 0, 6};
    stall_by_phase = '{0, 0, 45, 6};
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    sent_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items: a stray byte and the unused code while idle, an empty
    // directory, a dropped zero name byte, a start at the top sector number,
    // an append while searching, a restart with the largest size, and a
    // second empty directory that clears the name.
    send_byte(drs_pkg::OP_BYTE, 8'hFF);
    send_byte(OP_UNUSED, 8'h00);
    send(drs_pkg::OP_START, 8'h00, 32'h0000_0000, 32'h0000_0000);
    send_byte(drs_pkg::OP_APPEND, 8'h00);
    send_byte(drs_pkg::OP_APPEND, 8'hFF);
    send(drs_pkg::OP_START, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0001);
    send_byte(drs_pkg::OP_APPEND, 8'h42);
    send(drs_pkg::OP_START, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
    send(drs_pkg::OP_START, 8'h5A, 32'h1234_5678, 32'h0000_0000);
    // With the name now empty, a directory record whose name length is zero
    // is the hit.
    directory_search(0, 1, 32'h8000_0000, drs_pkg::SECTOR_BYTES, 0);

    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = idle_by_phase[phase];
      receiver_stall_pct = stall_by_phase[phase];
      case (phase)
        0: begin
          // Records run across the end of the first sector, and the second
          // sector number wraps to zero.
          load_name(8);
          directory_search(2100, 1, 32'hFFFF_FFFF, 2 * drs_pkg::SECTOR_BYTES,
                           2 * drs_pkg::SECTOR_BYTES);
        end
        1: begin
          // A whole sector without a hit ends in not found.
          load_name(5);
          directory_search(1500, 0, $urandom, drs_pkg::SECTOR_BYTES,
                           drs_pkg::SECTOR_BYTES);
        end
        2: begin
          load_name(3);
          directory_search(0, 0, $urandom, $urandom_range(1, drs_pkg::SECTOR_BYTES),
                           drs_pkg::SECTOR_BYTES);
        end
        default: begin
        end
      endcase
      target = sent_count + RANDOM_ITEMS / 4;
      while (sent_count < target) random_search();
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/drs_pkg.sv
sv/drs_front.sv
sv/drs_queue.sv
sv/drs_back.sv
sv/directory_record_search.sv
dv/tb_top.sv
